// ===== hdl/chs_pkg.sv =====
package chs_pkg;

    // action codes
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_TEST   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // field widths
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int CFG_W    = 11;
    localparam int COUNT_W  = 11;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // hash constants
    localparam logic [31:0] HASH_ADD    = 32'd23;
    localparam logic [31:0] HASH_PRIME  = 32'd2147483647;
    localparam logic [31:0] HASH_PRIME2 = 32'd4294967294;
    localparam int          HASH_BITS   = 31;

endpackage

// ===== hdl/chs_ram.sv =====
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/chained_hash_set_top.sv =====
// Hash set of 32-bit keys kept in bucket chains over a node pool.
//
// Input stream (s_axis): one word per operation, action 0 add, 1 test,
// 2 remove (3 acts as a test). Output stream (m_axis): one word per
// operation with was_present, pool_full and the element count afterwards.
// Config channel: write bucket_count (0 acts as 1, above BUCKETS saturates)
// only while the block is idle; stored keys are not rehashed.
//
// Sequence: a word is taken only in idle. Each operation runs a bit-serial
// modulo by the bucket count (ST_DIV, a subtract/compare unit), the bucket
// head read (ST_HEAD then ST_HEADW), a check and a node read per chain node
// visited (ST_CHK, ST_NODEW; registered-read node memories), a last check
// when the walk runs off the chain end, a decision (ST_ACT), then list
// updates for an add that stores a key (ST_POPW and ST_INS for a recycled
// node, ST_INS for a fresh one) or for a remove that finds it (ST_UNL), and
// ST_OUT to load the result. The input goes ready again as the result loads.
// The result sits in an output register; the next word is accepted while a
// result still waits, and the block only stalls at the end of an operation
// if the receiver still holds the previous result.
//
// Reset: the bucket head memory is swept to null, one entry per cycle, after
// reset; s_axis tready stays low during that pass.
// Nodes never used are handed out by a fill counter, recycled nodes from a
// free list. An add with no free node is refused with pool_full set.
module chained_hash_set_top
    import chs_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int POOL    = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [1:0] action, [33:2] key
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [0] was_present, [1] pool_full, [12:2] element_count
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = (POOL > 1) ? $clog2(POOL) : 1;   // node memory address
    localparam int PW = $clog2(POOL + 1);                 // node index incl. null
    localparam logic [PW-1:0] NIL = PW'(POOL);
    localparam int DCW = $clog2(HASH_BITS);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_HEAD, ST_HEADW, ST_CHK, ST_NODEW,
        ST_ACT, ST_POPW, ST_INS, ST_UNL, ST_OUT
    } t_state;

    t_state               r_state;
    logic [BW-1:0]        r_clr;
    logic [CFG_W-1:0]     r_cfg;
    logic [ACTION_W-1:0]  r_action;
    logic [KEY_W-1:0]     r_key;
    logic [CFG_W-1:0]     r_n;
    logic [HASH_BITS-1:0] r_div;
    logic [CFG_W-1:0]     r_rem;
    logic [DCW-1:0]       r_dcnt;
    logic [PW-1:0]        r_head;
    logic [PW-1:0]        r_cur;
    logic [PW-1:0]        r_prev;
    logic [PW-1:0]        r_next;
    logic [PW-1:0]        r_new;
    logic [PW-1:0]        r_free;
    logic [PW-1:0]        r_fresh;
    logic [PW-1:0]        r_count;
    logic                 r_found;
    logic                 r_refused;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic                 s_acc;
    logic [KEY_W-1:0]     in_key;
    logic [31:0]          h_sum;
    logic [31:0]          h_red;
    logic [CFG_W-1:0]     eff_n;
    logic [CFG_W:0]       rem_sh;
    logic [CFG_W:0]       rem_sub;
    logic [BW-1:0]        bucket;
    logic                 do_remove;

    // memory ports
    logic             head_we;
    logic [BW-1:0]    head_waddr;
    logic [PW-1:0]    head_wdata;
    logic [BW-1:0]    head_raddr;
    logic [PW-1:0]    head_rdata;
    logic             key_we;
    logic [NW-1:0]    node_raddr;
    logic [KEY_W-1:0] key_rdata;
    logic             link_we;
    logic [NW-1:0]    link_waddr;
    logic [PW-1:0]    link_wdata;
    logic [PW-1:0]    link_raddr;
    logic [PW-1:0]    link_rdata;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_key = i_s_axis_tdata[ACTION_W +: KEY_W];

    // (key + 23) mod 2^32, then mod 2^31-1 (value below three times the prime)
    always_comb begin
        h_sum = in_key + HASH_ADD;
        if (h_sum >= HASH_PRIME2) begin
            h_red = h_sum - HASH_PRIME2;
        end else if (h_sum >= HASH_PRIME) begin
            h_red = h_sum - HASH_PRIME;
        end else begin
            h_red = h_sum;
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            eff_n = CFG_W'(1);
        end else if (32'(r_cfg) > BUCKETS) begin
            eff_n = CFG_W'(BUCKETS);
        end else begin
            eff_n = r_cfg;
        end
    end

    // one restoring-division step per cycle
    assign rem_sh  = {r_rem, r_div[HASH_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, r_n};
    assign bucket  = BW'(r_rem);

    assign do_remove = (r_action == ACT_REMOVE) && r_found;

    always_comb begin
        head_we    = 1'b0;
        head_waddr = bucket;
        head_wdata = r_new;
        head_raddr = bucket;
        key_we     = (r_state == ST_INS);
        node_raddr = NW'(r_cur);
        link_we    = 1'b0;
        link_waddr = NW'(r_new);
        link_wdata = r_head;
        link_raddr = r_cur;
        unique case (r_state)
            ST_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = NIL;
            end
            ST_INS: begin
                head_we = 1'b1;
                link_we = 1'b1;
            end
            ST_ACT: begin
                link_raddr = r_free;
                if (do_remove) begin
                    if (r_prev == NIL) begin
                        head_we    = 1'b1;
                        head_wdata = r_next;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = NW'(r_prev);
                        link_wdata = r_next;
                    end
                end
            end
            ST_UNL: begin
                link_we    = 1'b1;
                link_waddr = NW'(r_cur);
                link_wdata = r_free;
            end
            default: begin
            end
        endcase
    end

    chs_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    chs_ram #(.WIDTH(KEY_W), .DEPTH(POOL)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (NW'(r_new)),
        .i_wdata (r_key),
        .i_raddr (node_raddr),
        .o_rdata (key_rdata)
    );

    chs_ram #(.WIDTH(PW), .DEPTH(POOL)) u_links (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (NW'(link_raddr)),
        .o_rdata (link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cfg       <= CFG_W'(1024);
            r_free      <= NIL;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            // in ST_OUT the valid flag is handled by the state itself
            if (r_out_valid && i_m_axis_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == BUCKETS - 1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        r_action  <= i_s_axis_tdata[ACTION_W-1:0];
                        r_key     <= in_key;
                        r_n       <= eff_n;
                        r_div     <= h_red[HASH_BITS-1:0];
                        r_rem     <= '0;
                        r_dcnt    <= '0;
                        r_found   <= 1'b0;
                        r_refused <= 1'b0;
                        r_state   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_div  <= {r_div[HASH_BITS-2:0], 1'b0};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (rem_sh >= {1'b0, r_n}) begin
                        r_rem <= rem_sub[CFG_W-1:0];
                    end else begin
                        r_rem <= rem_sh[CFG_W-1:0];
                    end
                    if (32'(r_dcnt) == HASH_BITS - 1) begin
                        r_state <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    r_state <= ST_HEADW;
                end
                ST_HEADW: begin
                    r_head  <= head_rdata;
                    r_cur   <= head_rdata;
                    r_prev  <= NIL;
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    r_state <= (r_cur == NIL) ? ST_ACT : ST_NODEW;
                end
                ST_NODEW: begin
                    if (key_rdata == r_key) begin
                        r_found <= 1'b1;
                        r_next  <= link_rdata;
                        r_state <= ST_ACT;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= link_rdata;
                        r_state <= ST_CHK;
                    end
                end
                ST_ACT: begin
                    if (r_action == ACT_ADD && !r_found) begin
                        if (r_free != NIL) begin
                            r_new   <= r_free;
                            r_state <= ST_POPW;
                        end else if (r_fresh != NIL) begin
                            r_new   <= r_fresh;
                            r_fresh <= r_fresh + 1'b1;
                            r_state <= ST_INS;
                        end else begin
                            r_refused <= 1'b1;
                            r_state   <= ST_OUT;
                        end
                    end else if (do_remove) begin
                        r_state <= ST_UNL;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_POPW: begin
                    r_free  <= link_rdata;
                    r_state <= ST_INS;
                end
                ST_INS: begin
                    r_count <= r_count + 1'b1;
                    r_state <= ST_OUT;
                end
                ST_UNL: begin
                    r_free <= r_cur;
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {3'b000, COUNT_W'(r_count), r_refused, r_found};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // occupancy never exceeds the pool
    assert property (@(posedge i_clk) disable iff (!i_rst_n) 32'(r_count) <= POOL)
        else $error("element count above pool size");

    // a refused add never reports the key as present
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]))
        else $error("pool_full with was_present");

    // one word at a time: after acceptance the input side closes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted back to back");

    // a fresh node is only handed out while the fill counter is in range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |-> (r_new != NIL))
        else $error("insert of null node");

endmodule

// ===== tb/chs_checker.sv =====
`timescale 1ns / 100ps

// Watches the config, op and result channels of the hash set, keeps its own
// model of the chains and compares every result word with the oldest
// prediction.
module chs_checker
    import chs_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int POOL    = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_refused
);

    // lowest bit last: matches the result word layout
    typedef struct packed {
        logic [COUNT_W-1:0] element_count;
        logic               pool_full;
        logic               was_present;
    } t_set_result;

    localparam int NIL = POOL;

    int           heads [BUCKETS];
    logic [31:0]  node_key [POOL];
    int           node_next [POOL];
    int           free_node;
    logic [COUNT_W-1:0] stored;
    logic [CFG_W-1:0]   nbuckets;

    t_set_result  expected_results [$];

    function automatic int bucket_index(logic [31:0] key);
        logic [31:0] h;
        int          n;
        h = key + HASH_ADD;
        h = h % HASH_PRIME;
        n = nbuckets;
        if (n == 0) n = 1;
        if (n > BUCKETS) n = BUCKETS;
        return int'(h % n);
    endfunction

    function automatic t_set_result apply_op(logic [1:0] action, logic [31:0] key);
        t_set_result r;
        int b, prev, cur, steps, n;
        logic found;
        b = bucket_index(key);
        prev = NIL;
        cur = heads[b];
        steps = 0;
        found = 1'b0;
        r = '0;
        while (cur < POOL && steps < POOL) begin
            if (node_key[cur] == key) begin
                found = 1'b1;
                break;
            end
            prev = cur;
            cur = node_next[cur];
            steps++;
        end
        if (action == ACT_ADD && !found) begin
            if (free_node >= POOL) begin
                r.pool_full = 1'b1;
            end else begin
                n = free_node;
                free_node = node_next[n];
                node_key[n] = key;
                node_next[n] = heads[b];
                heads[b] = n;
                stored = stored + 1'b1;
            end
        end else if (action == ACT_REMOVE && found) begin
            if (prev < POOL) node_next[prev] = node_next[cur];
            else heads[b] = node_next[cur];
            node_next[cur] = free_node;
            free_node = cur;
            if (stored != 0) stored = stored - 1'b1;
        end
        r.was_present   = found;
        r.element_count = stored;
        return r;
    endfunction

    initial begin
        for (int i = 0; i < BUCKETS; i++) heads[i] = NIL;
        for (int i = 0; i < POOL; i++) begin
            node_key[i]  = '0;
            node_next[i] = i + 1;
        end
        free_node    = 0;
        stored       = '0;
        nbuckets     = CFG_W'(1024);
        o_fail_count = 0;
        o_refused    = 0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_set_result exp_r, got;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) nbuckets <= i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(apply_op(i_s_tdata[1:0], i_s_tdata[33:2]));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[12:0];
                if (got.pool_full) o_refused <= o_refused + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result word %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r || i_m_tdata[15:13] !== 3'b0) begin
                        if (o_fail_count < 10)
                            $display({"ERROR: result mismatch: present %b/%b ",
                                      "full %b/%b count %0d/%0d (exp/act)"},
                                exp_r.was_present, got.was_present, exp_r.pool_full,
                                got.pool_full, exp_r.element_count, got.element_count);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_chained_hash_set_top.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the chained hash set. Ops go in on s_axis in
// random bursts; results leave on m_axis under a shifting stall pattern.
// The checker beside the block does all prediction and comparison.
module tb_chained_hash_set_top;
    import chs_pkg::*;

    localparam int BUCKETS = 1024;
    localparam int POOL    = 1024;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count, pending, refused;
    int ops_sent;
    int cfg_writes;
    int burst_left;
    logic [31:0] added_keys [$];

    chained_hash_set_top #(.BUCKETS(BUCKETS), .POOL(POOL)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    chs_checker #(.BUCKETS(BUCKETS), .POOL(POOL)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_refused    (refused)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop; generous against ~2000 ops in the worst case plus the
    // head-clearing sweep after reset.
    initial begin
        #30ms;
        $display("ERROR: timeout");
        $display("tb_chained_hash_set_top NOT OK");
        $finish;
    end

    // Receiver: stall mode changes every so often; once, a long hold-off
    // lets the block back up and stall its input.
    initial begin
        int mode, left, hold;
        logic long_done;
        m_tready  = 1'b0;
        long_done = 1'b0;
        mode = 0;
        left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!long_done && ops_sent >= 500) begin
                long_done = 1'b1;
                m_tready <= 1'b0;
                for (hold = 0; hold < 600; hold++) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 9) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // One op word; bursts of random length separated by random gaps.
    task automatic send_op(logic [1:0] action, logic [31:0] key);
        int   gap;
        logic taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, key, action};
        // tready only moves just after a rising edge; sample it mid-cycle
        do begin
            @(negedge i_clk);
            taken = s_tready;
            @(posedge i_clk);
        end while (!taken);
        ops_sent++;
        if (action == ACT_ADD) added_keys.push_back(key);
    endtask

    // Drain: sender pauses until every result is back, then a short margin.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [CFG_W-1:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] old_key();
        if (added_keys.size() == 0) return $urandom;
        return added_keys[$urandom_range(0, added_keys.size() - 1)];
    endfunction

    // Mixed traffic: mostly ops on a small key set so chains hit often,
    // some on earlier keys, some fully random; action 3 now and then.
    task automatic mixed_ops(int n, int key_span);
        logic [1:0]  act;
        logic [31:0] key;
        int          pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            act  = 2'($urandom_range(0, 3));
            if (pick < 6) key = $urandom_range(0, key_span - 1) ^ 32'hFFFF_0000;
            else if (pick < 8) key = old_key();
            else key = $urandom;
            send_op(act, key);
        end
    endtask

    initial begin
        logic [1:0] act;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        ops_sent   = 0;
        cfg_writes = 0;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: hash edges, duplicate add, double remove, unused action
        write_buckets(CFG_W'(1024));
        send_op(ACT_ADD, 32'h0);
        send_op(ACT_ADD, 32'h0);
        send_op(ACT_TEST, 32'h0);
        send_op(2'd3, 32'h0);
        send_op(ACT_REMOVE, 32'h0);
        send_op(ACT_REMOVE, 32'h0);
        send_op(ACT_TEST, 32'h0);
        send_op(ACT_ADD, 32'hFFFF_FFFF);    // key+23 wraps
        send_op(ACT_ADD, 32'hFFFF_FFE8);    // sum is 2^32-1
        send_op(ACT_ADD, 32'hFFFF_FFE9);    // sum wraps to 0
        send_op(ACT_ADD, 32'h7FFF_FFE8);    // sum equals the prime
        send_op(ACT_TEST, 32'hFFFF_FFE8);
        send_op(ACT_REMOVE, 32'hFFFF_FFFF);
        send_op(ACT_TEST, 32'hFFFF_FFFF);
        send_op(2'd3, 32'h7FFF_FFE8);
        send_op(ACT_REMOVE, 32'hAAAA_5555);

        // zero acts as one bucket: every key on one chain
        write_buckets(CFG_W'(0));
        mixed_ops(60, 12);
        write_buckets(CFG_W'(1));
        mixed_ops(60, 12);

        // saturated count; mostly adds to fill the pool
        write_buckets(CFG_W'(2047));
        for (int i = 0; i < 1150; i++) begin
            if ($urandom_range(0, 99) < 88) begin
                send_op(ACT_ADD, $urandom);
            end else begin
                act = 2'($urandom_range(1, 3));
                send_op(act, old_key());
            end
        end
        mixed_ops(150, 64);

        // shrink with keys held: no rehash, old keys partly lost
        write_buckets(CFG_W'(7));
        mixed_ops(200, 24);

        for (int p = 0; p < 3; p++) begin
            write_buckets(CFG_W'($urandom_range(1, 1024)));
            mixed_ops(90, 48);
        end
        write_buckets(CFG_W'(1024));
        mixed_ops(60, 32);

        drain();
        $display("Covered %0d ops over %0d bucket-count writes, %0d refused adds.",
                 ops_sent, cfg_writes, refused);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_chained_hash_set_top OK");
        end else begin
            $display("failures %0d, results missing %0d", fail_count, pending);
            $display("tb_chained_hash_set_top NOT OK");
        end
        $finish;
    end

endmodule
